// ===== rtl/core/qep_pkg.sv =====
`default_nettype none

package qep_pkg;

  // Default width of the fine count and detent position
  localparam int unsigned CountWidthDef = 16;

  // Widths fixed by the register map and the word layout
  localparam int unsigned PosWidth     = 8;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned InDataWidth  = 8;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegLatchMode  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegRangeMin   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegRangeMax   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegWrapEnable = 2'd3;

  // Latch modes
  localparam logic [1:0] LatchNone = 2'd0;
  localparam logic [1:0] LatchFour = 2'd1;
  localparam logic [1:0] LatchTwo  = 2'd2;

  // Detent phases
  localparam logic [1:0] PhaseZero  = 2'd0;
  localparam logic [1:0] PhaseThree = 2'd3;

  // Quadrature step table, indexed by {old phase, new phase}
  function automatic logic signed [1:0] step_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default:                  d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/quadrature_encoder_position.sv =====
`default_nettype none

// Quadrature encoder position decoder. Each input word is one sample of the two
// active-low encoder pins; each sample yields exactly one output word carrying
// the 8-bit detent position after the range clamp or wrap. The block takes one
// sample per clock while the output is not stalled and answers through the input
// register, then the result register; the rate is set by the fine count and detent
// position feedback, which closes through a table add, shift and compare.
// The config port is always ready and must only be written while no sample is
// in flight.
module quadrature_encoder_position #(
  parameter int unsigned CountWidth = qep_pkg::CountWidthDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input stream
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire  [qep_pkg::InDataWidth-1:0]    s_axis_tdata_i,  // [0] channel_a, [1] channel_b
  // output stream
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  output logic [qep_pkg::PosWidth-1:0]       m_axis_tdata_o,  // [7:0] position
  // config write
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [qep_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire  [qep_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import qep_pkg::*;

  // config registers
  logic [1:0]          latch_mode_q;
  logic [PosWidth-1:0] range_min_q;
  logic [PosWidth-1:0] range_max_q;
  logic                wrap_enable_q;

  // pipeline
  logic                in_valid_q;
  logic [1:0]          phase_q;
  logic                out_valid_q;
  logic [PosWidth-1:0] out_pos_q;
  logic [PosWidth-1:0] out_pos_d;

  // decoder state
  logic [1:0]                   last_phase_q;
  logic signed [CountWidth-1:0] fine_q, fine_d;
  logic signed [CountWidth-1:0] detent_q, detent_d;

  logic out_free;
  logic proc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_mode_q  <= LatchFour;
      range_min_q   <= '0;
      range_max_q   <= '1;
      wrap_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLatchMode:  latch_mode_q  <= cfg_data_i[1:0];
        RegRangeMin:   range_min_q   <= cfg_data_i[PosWidth-1:0];
        RegRangeMax:   range_max_q   <= cfg_data_i[PosWidth-1:0];
        RegWrapEnable: wrap_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: a word moves on when the result register is free or draining
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pos_q;

  // input register: store the active-high phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      phase_q <= ~s_axis_tdata_i[1:0];
    end
  end

  // decode one sample
  logic [1:0]                   mode;
  logic signed [CountWidth-1:0] fine_step;
  logic signed [CountWidth-1:0] det_latch;
  logic signed [CountWidth-1:0] min_ext, max_ext;
  logic                         below, above, out_rng;
  logic [PosWidth-1:0]          target;
  logic signed [1:0]            delta;

  always_comb begin
    mode = (latch_mode_q == LatchNone) ? LatchNone :
           (latch_mode_q == LatchFour) ? LatchFour : LatchTwo;

    // fine count step on a phase change
    delta     = step_delta({last_phase_q, phase_q});
    fine_step = fine_q;
    if (phase_q != last_phase_q) begin
      fine_step = fine_q + {{(CountWidth-2){delta[1]}}, delta};
    end

    // latch at the detent phases
    det_latch = detent_q;
    if (mode == LatchFour && phase_q == PhaseThree) begin
      det_latch = fine_step >>> 2;
    end else if (mode == LatchTwo && (phase_q == PhaseZero || phase_q == PhaseThree)) begin
      det_latch = fine_step >>> 1;
    end

    // range check, low bound first
    min_ext = $signed({{(CountWidth-PosWidth){1'b0}}, range_min_q});
    max_ext = $signed({{(CountWidth-PosWidth){1'b0}}, range_max_q});
    below   = det_latch < min_ext;
    above   = !below && (det_latch > max_ext);
    out_rng = below || above;

    if (wrap_enable_q) begin
      target = below ? range_max_q : range_min_q;
    end else begin
      target = below ? range_min_q : range_max_q;
    end

    // rewrite keeps the sub-detent bits
    fine_d   = fine_step;
    detent_d = det_latch;
    if (out_rng && mode == LatchFour) begin
      fine_d   = $signed((CountWidth'(target) << 2) | CountWidth'(fine_step[1:0]));
      detent_d = $signed(CountWidth'(target));
    end else if (out_rng && mode == LatchTwo) begin
      fine_d   = $signed((CountWidth'(target) << 1) | CountWidth'(fine_step[0]));
      detent_d = $signed(CountWidth'(target));
    end

    // saturate reports the bound; wrap reports the opposite bound, or the held position in latch mode none
    if (out_rng && (!wrap_enable_q || mode != LatchNone)) begin
      out_pos_d = target;
    end else begin
      out_pos_d = det_latch[PosWidth-1:0];
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= '0;
      fine_q       <= '0;
      detent_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (proc) begin
        last_phase_q <= phase_q;
        fine_q       <= fine_d;
        detent_q     <= detent_d;
      end
      if (out_free) begin
        out_valid_q <= proc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_pos_q <= out_pos_d;
    end
  end

`ifndef SYNTHESIS
  // a held sample with a stalled result register blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while pipeline is full");

  // decoder state only moves when a word is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(last_phase_q) && $stable(fine_q) && $stable(detent_q))
    else $error("decoder state changed without a word");

  // with no latch update the detent position is frozen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && latch_mode_q == LatchNone |=> $stable(detent_q))
    else $error("detent position changed in latch mode zero");

  // saturation keeps the reported position inside an ordered range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !wrap_enable_q && range_min_q <= range_max_q |=>
      out_pos_q >= $past(range_min_q) && out_pos_q <= $past(range_max_q))
    else $error("saturated position outside range");
`endif

endmodule

`default_nettype wire
